// File: rtl/srd_pkg.sv
// Shared constants, types and helper functions of the stick radial deadzone block.
`default_nettype none

package srd_pkg;

   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned DIV_STEPS  = 15;

   localparam logic [15:0] WEIGHT_RESET = 16'd15990;
   localparam logic [30:0] THR_RESET    = 31'd523944330;
   localparam logic [15:0] OUT_MAX      = 16'd32767;

   localparam int unsigned ADDR_W     = 3;
   localparam logic        REG_WEIGHT = 1'b0;

   typedef struct packed {
      logic        valid;
      logic [15:0] mag_x;
      logic [15:0] mag_y;
      logic        neg_x;
      logic        neg_y;
   } side_type;

   typedef struct packed {
      logic valid;
      logic zero;
      logic neg_x;
      logic neg_y;
   } tail_type;

   function automatic logic [15:0] abs16(input logic [15:0] a);
      abs16 = a[15] ? 16'(~a + 16'd1) : a;
   endfunction

endpackage

`default_nettype wire

// File: rtl/srd_isqrt.sv
// Pipelined digit-by-digit integer square root of a 32-bit value scaled by 2^32.
`default_nettype none

module srd_isqrt import srd_pkg::*; (
   input  wire logic        clock,
   input  wire logic [31:0] rad_i,
   output logic      [31:0] root_o
);

   logic [35:0] rem_ff  [SQRT_STEPS];
   logic [31:0] root_ff [SQRT_STEPS];
   logic [31:0] src_ff  [SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      logic [35:0] rem_prev;
      logic [31:0] root_prev;
      logic [31:0] src_prev;
      logic [35:0] rem_sh;
      logic [35:0] trial;

      if (j == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign src_prev  = rad_i;
      end else begin : g_rest
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign src_prev  = src_ff[j-1];
      end

      // Two more radicand bits come down; the low half of the radicand is zero.
      assign rem_sh = {rem_prev[33:0], src_prev[31:30]};
      assign trial  = {2'b00, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         src_ff[j] <= {src_prev[29:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff[j]  <= rem_sh - trial;
            root_ff[j] <= {root_prev[30:0], 1'b1};
         end else begin
            rem_ff[j]  <= rem_sh;
            root_ff[j] <= {root_prev[30:0], 1'b0};
         end
      end
   end

   assign root_o = root_ff[SQRT_STEPS-1];

endmodule

`default_nettype wire

// File: rtl/srd_div.sv
// Pipelined restoring divider giving a 15-bit quotient and an overflow flag.
`default_nettype none

module srd_div import srd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic [63:0]          num_i,
   input  wire logic [48:0]          den_i,
   output logic      [DIV_STEPS-1:0] quo_o,
   output logic                      sat_o
);

   logic [63:0]          rem_ff [DIV_STEPS+1];
   logic [48:0]          den_ff [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] quo_ff [DIV_STEPS+1];
   logic                 sat_ff [DIV_STEPS+1];

   // First stage flags a quotient that does not fit in the result range.
   always_ff @(posedge clock) begin
      rem_ff[0] <= num_i;
      den_ff[0] <= den_i;
      quo_ff[0] <= '0;
      sat_ff[0] <= num_i >= (64'(den_i) << DIV_STEPS);
   end

   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
      logic [63:0] dsh;
      assign dsh = 64'(den_ff[j-1]) << (DIV_STEPS - j);

      always_ff @(posedge clock) begin
         den_ff[j] <= den_ff[j-1];
         sat_ff[j] <= sat_ff[j-1];
         if (rem_ff[j-1] >= dsh) begin
            rem_ff[j] <= rem_ff[j-1] - dsh;
            quo_ff[j] <= quo_ff[j-1] | (DIV_STEPS'(1) << (DIV_STEPS - j));
         end else begin
            rem_ff[j] <= rem_ff[j-1];
            quo_ff[j] <= quo_ff[j-1];
         end
      end
   end

   assign quo_o = quo_ff[DIV_STEPS];
   assign sat_o = sat_ff[DIV_STEPS];

endmodule

`default_nettype wire

// File: rtl/stick_radial_deadzone_top.sv
// Top level of the stick radial deadzone block: pipeline, register file and checks.
//
//   Channel   Direction  Handshake                    Word
//   request   in         start high and busy low      req_raw_x, req_raw_y
//   response  out        rsp_strobe for one cycle     rsp_out_x, rsp_out_y
//   csr       in/out     psel, penable, pwrite, pready deadzone_weight at byte 0
//
// A word is accepted in every cycle; busy is never raised.
// The depth of the pipeline from request to response is set by the 32-stage square root
// (one result bit per stage) and the 16-stage divider.
// Synchronous reset clears the valid bits and loads the default weight.
// The response side cannot stall, so words march through the pipeline every cycle.
`default_nettype none

module stick_radial_deadzone_top import srd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_raw_x,
   input  wire logic signed [15:0] req_raw_y,
   output logic                    rsp_strobe,
   output logic signed [15:0]      rsp_out_x,
   output logic signed [15:0]      rsp_out_y,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [ADDR_W-1:0]  paddr,
   input  wire logic [31:0]        pwdata,
   output logic      [31:0]        prdata,
   output logic                    pready
);

   localparam int unsigned LATENCY = 4 + SQRT_STEPS + 2 + DIV_STEPS + 1 + 1;

   // Configuration. The threshold w*32767 is kept alongside the weight so the
   // pipeline never multiplies by it.
   logic [15:0] weight_ff;
   logic [30:0] thr_ff;
   logic [15:0] weight_in;
   logic [30:0] thr_in;
   logic        wr_en;
   logic [16:0] wm;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign wr_en     = psel && penable && pwrite && pready && (paddr[ADDR_W-1] == REG_WEIGHT);
   assign weight_in = pwdata[15:0];
   assign thr_in    = {weight_in, 15'b0} - 31'(weight_in);
   assign prdata    = (paddr[ADDR_W-1] == REG_WEIGHT) ? {16'b0, weight_ff} : 32'b0;
   assign wm        = 17'h10000 - {1'b0, weight_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
         thr_ff    <= THR_RESET;
      end else if (wr_en) begin
         weight_ff <= weight_in;
         thr_ff    <= thr_in;
      end
   end

   // Stage 1 registers the incoming word.
   logic        v1_ff;
   logic [15:0] x1_ff, y1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start && !busy;
      x1_ff <= req_raw_x;
      y1_ff <= req_raw_y;
   end

   // Stage 2 takes magnitudes and zeroes each axis below the threshold on its own.
   side_type s2_ff;
   side_type s2_in;
   logic [15:0] ax, ay;

   assign ax = abs16(x1_ff);
   assign ay = abs16(y1_ff);

   always_comb begin
      s2_in.valid = v1_ff;
      s2_in.mag_x = ({ax, 16'b0} >= {1'b0, thr_ff}) ? ax : 16'd0;
      s2_in.mag_y = ({ay, 16'b0} >= {1'b0, thr_ff}) ? ay : 16'd0;
      s2_in.neg_x = x1_ff[15];
      s2_in.neg_y = y1_ff[15];
   end

   // Stage 3 squares, stage 4 adds.
   side_type    s3_ff, s4_ff;
   logic [31:0] sqx3_ff, sqy3_ff, sum4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else begin
         s2_ff.valid <= s2_in.valid;
         s3_ff.valid <= s2_ff.valid;
         s4_ff.valid <= s3_ff.valid;
      end
      {s2_ff.mag_x, s2_ff.mag_y, s2_ff.neg_x, s2_ff.neg_y} <=
         {s2_in.mag_x, s2_in.mag_y, s2_in.neg_x, s2_in.neg_y};
      {s3_ff.mag_x, s3_ff.mag_y, s3_ff.neg_x, s3_ff.neg_y} <=
         {s2_ff.mag_x, s2_ff.mag_y, s2_ff.neg_x, s2_ff.neg_y};
      {s4_ff.mag_x, s4_ff.mag_y, s4_ff.neg_x, s4_ff.neg_y} <=
         {s3_ff.mag_x, s3_ff.mag_y, s3_ff.neg_x, s3_ff.neg_y};
      sqx3_ff <= s2_ff.mag_x * s2_ff.mag_x;
      sqy3_ff <= s2_ff.mag_y * s2_ff.mag_y;
      sum4_ff <= sqx3_ff + sqy3_ff;
   end

   // Radius in raw units with 16 fraction bits; the side word rides a matching delay line.
   logic [31:0] root;
   side_type    sq_side_ff [SQRT_STEPS];

   srd_isqrt u_isqrt (
      .clock  (clock),
      .rad_i  (sum4_ff),
      .root_o (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQRT_STEPS; i++) sq_side_ff[i] <= '0;
      end else begin
         sq_side_ff[0] <= s4_ff;
         for (int i = 1; i < SQRT_STEPS; i++) sq_side_ff[i] <= sq_side_ff[i-1];
      end
   end

   // Stage A: deadzone test (radius below threshold, or no direction at all),
   // the ramp distance and the divisor R*(65536-w).
   side_type    sa_ff;
   logic        zero_a_ff;
   logic [31:0] dist_a_ff;
   logic [48:0] den_a_ff;

   always_ff @(posedge clock) begin
      if (reset) sa_ff.valid <= 1'b0;
      else       sa_ff.valid <= sq_side_ff[SQRT_STEPS-1].valid;
      {sa_ff.mag_x, sa_ff.mag_y, sa_ff.neg_x, sa_ff.neg_y} <=
         {sq_side_ff[SQRT_STEPS-1].mag_x, sq_side_ff[SQRT_STEPS-1].mag_y,
          sq_side_ff[SQRT_STEPS-1].neg_x, sq_side_ff[SQRT_STEPS-1].neg_y};
      zero_a_ff <= (root < {1'b0, thr_ff}) || (root == 32'd0);
      dist_a_ff <= root - {1'b0, thr_ff};
      den_a_ff  <= root * wm;
   end

   // Stage B: dividends |a|*(R-thr)*65536 for both axes.
   tail_type    tb_ff;
   logic [63:0] num_x_ff, num_y_ff;
   logic [48:0] den_b_ff;
   logic [47:0] prod_x, prod_y;

   assign prod_x = sa_ff.mag_x * dist_a_ff;
   assign prod_y = sa_ff.mag_y * dist_a_ff;

   always_ff @(posedge clock) begin
      if (reset) tb_ff.valid <= 1'b0;
      else       tb_ff.valid <= sa_ff.valid;
      tb_ff.zero  <= zero_a_ff;
      tb_ff.neg_x <= sa_ff.neg_x;
      tb_ff.neg_y <= sa_ff.neg_y;
      num_x_ff    <= {prod_x, 16'b0};
      num_y_ff    <= {prod_y, 16'b0};
      den_b_ff    <= den_a_ff;
   end

   // One divider lane per axis, sharing the divisor.
   logic [DIV_STEPS-1:0] quo_x, quo_y;
   logic                 sat_x, sat_y;
   tail_type             tail_ff [DIV_STEPS+1];

   srd_div u_div_x (
      .clock (clock),
      .num_i (num_x_ff),
      .den_i (den_b_ff),
      .quo_o (quo_x),
      .sat_o (sat_x)
   );

   srd_div u_div_y (
      .clock (clock),
      .num_i (num_y_ff),
      .den_i (den_b_ff),
      .quo_o (quo_y),
      .sat_o (sat_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STEPS; i++) tail_ff[i] <= '0;
      end else begin
         tail_ff[0] <= tb_ff;
         for (int i = 1; i <= DIV_STEPS; i++) tail_ff[i] <= tail_ff[i-1];
      end
   end

   // Output stage: saturate, force the deadzone to zero and restore the sign.
   logic [15:0] mag_x, mag_y;
   logic [15:0] out_x_in, out_y_in;

   assign mag_x = tail_ff[DIV_STEPS].zero ? 16'd0 : (sat_x ? OUT_MAX : {1'b0, quo_x});
   assign mag_y = tail_ff[DIV_STEPS].zero ? 16'd0 : (sat_y ? OUT_MAX : {1'b0, quo_y});
   assign out_x_in = tail_ff[DIV_STEPS].neg_x ? 16'(16'd0 - mag_x) : mag_x;
   assign out_y_in = tail_ff[DIV_STEPS].neg_y ? 16'(16'd0 - mag_y) : mag_y;

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else       rsp_strobe <= tail_ff[DIV_STEPS].valid;
      rsp_out_x <= out_x_in;
      rsp_out_y <= out_y_in;
   end

   // Every accepted word is followed by a response strobe after the pipeline latency.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("response missing after fixed latency");

   // A centered stick always lands at rest.
   a_center : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_raw_x == 16'sd0 && req_raw_y == 16'sd0)
      |-> ##LATENCY (rsp_out_x == 16'sd0 && rsp_out_y == 16'sd0))
      else $error("centered input did not give zero output");

   // Saturation never lets the most negative code through.
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_out_x != 16'sh8000 && rsp_out_y != 16'sh8000))
      else $error("output outside saturated range");

endmodule

`default_nettype wire
